### rtl/tkrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrs_pkg - shared definitions for the top-k run statistics block
// Widths, reset values, register indexes, controller states and the
// structs that pass between the controller, the cell row and the divider.
// ----------------------------------------------------------------------------
package tkrs_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int RUN_LEN_W    = 16;
    localparam int KEEP_CNT_W   = 10;
    localparam int SUM_W        = 48;
    localparam int FRAC_W       = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 120;
    localparam int OUT_TUSER_W  = 1;

    localparam int DIV_NUM_W    = 48;
    localparam int DIV_DEN_W    = 16;
    localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

    localparam int KEEP_MAX_DEF = 512;

    localparam logic [RUN_LEN_W-1:0]  RUN_LEN_RST  = RUN_LEN_W'(10000);
    localparam logic [KEEP_CNT_W-1:0] KEEP_CNT_RST = KEEP_CNT_W'(500);
    localparam logic [FRAC_W-1:0]     FRAC_ONE     = FRAC_W'(65536);

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = CFG_IDX_W'(1);

    // result status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_ABORT = 1'b1;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_DRAIN,
        S_DIV_RUN,
        S_DIV_TOP,
        S_DIV_FRAC,
        S_PUSH
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic                ins;
        logic                shift;
        logic [SAMPLE_W-1:0] sample;
    } t_cell_ctl;

    // what a cell hands to its neighbors
    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                ge;
    } t_cell_link;

    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

endpackage

### rtl/tkrs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrs_cell - one slot of the sorted keep list
// Holds one kept sample. On an insert it keeps its value, takes the new
// sample or takes its left neighbor's value; on a drain it takes the right
// neighbor's value so the list streams out through slot zero.
// ----------------------------------------------------------------------------
module tkrs_cell (
    input  logic                                   i_clk,
    input  tkrs_pkg::t_cell_ctl                    i_ctl,
    input  logic                                   i_in_list,
    input  logic                                   i_in_range,
    input  tkrs_pkg::t_cell_link                   i_left,
    input  logic signed [tkrs_pkg::SAMPLE_W-1:0]   i_right_val,
    output tkrs_pkg::t_cell_link                   o_link
);
    import tkrs_pkg::*;

    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] n_val;
    logic                       w_ge;

    // equal entries stay ahead of the new sample
    assign w_ge = i_in_list && (r_val >= $signed(i_ctl.sample));

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (i_ctl.ins && i_in_range && !w_ge) begin
            n_val = i_left.ge ? $signed(i_ctl.sample) : $signed(i_left.val);
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.val = r_val;
    assign o_link.ge  = w_ge;

endmodule

### rtl/tkrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrs_div - shared restoring divider
// Divides an unsigned magnitude by an unsigned divisor, one quotient bit per
// cycle, and applies the sign at the end so the result truncates to zero.
// ----------------------------------------------------------------------------
module tkrs_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tkrs_pkg::t_div_req             i_req,
    output logic                           o_done,
    output logic [tkrs_pkg::DIV_NUM_W-1:0] o_quo
);
    import tkrs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_neg;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_bit;
    logic [DIV_DEN_W-1:0] w_rem_next;

    always_comb begin
        w_rem_sh   = {r_rem, r_quo[DIV_NUM_W-1]};
        w_diff     = w_rem_sh - {1'b0, r_den};
        w_bit      = w_rem_sh >= {1'b0, r_den};
        w_rem_next = w_bit ? w_diff[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_bit};
            r_rem <= w_rem_next;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (~r_quo + DIV_NUM_W'(1)) : r_quo;

endmodule

### rtl/top_k_run_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_run_statistics - run statistics with a sorted list of largest samples
// Accumulates a run of Q16.16 samples and reports run average, kept
// threshold, kept average and hit fraction at the end of every run.
// ----------------------------------------------------------------------------
// Samples enter at one word per cycle while a run is in progress. The kept
// list lives in a row of KEEP_MAX cells sorted largest first; every cell
// compares the incoming sample with its own value and either holds, takes
// the sample or takes its left neighbor's value, so an insert is done by all
// cells at once however long the list is. When the last sample of a run
// arrives the input stalls: the row drains through cell zero (one entry per
// cycle) to form the kept sum and threshold, then a one-bit-per-cycle
// divider forms the three quotients in turn, and the result then moves to
// the output register once that register is free. A fail word aborts the
// run, clears all counters and posts a status result with zero values; it
// stalls the input only until that result moves to the output register.
// Results go to an output register, so a new run starts while the last
// result still waits for m_axis_tready; only a second result stalls behind
// a full output register. Configuration (run_length index 0, keep_count
// index 1) is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce.
// ----------------------------------------------------------------------------
module top_k_run_statistics #(
    parameter int KEEP_MAX = tkrs_pkg::KEEP_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [tkrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tkrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] sample
    input  logic [tkrs_pkg::SAMPLE_W-1:0]     s_axis_tdata,
    // [0] hit, [1] fail
    input  logic [tkrs_pkg::IN_TUSER_W-1:0]   s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] run_average, [63:32] top_threshold, [95:64] top_average,
    // [112:96] hit_fraction, [119:113] zero
    output logic [tkrs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] status
    output logic [tkrs_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import tkrs_pkg::*;

    localparam int KW = $clog2(KEEP_MAX + 1);
    localparam int CW = (KW > KEEP_CNT_W) ? KW : KEEP_CNT_W;
    localparam int SW = SAMPLE_W + KW;

    // configuration
    logic [RUN_LEN_W-1:0]  r_run_len;
    logic [KEEP_CNT_W-1:0] r_keep_cnt;

    // run state
    t_state                r_state, n_state;
    logic [KW-1:0]         r_kept_num;
    logic [RUN_LEN_W-1:0]  r_sample_cnt;
    logic [SUM_W-1:0]      r_sum;
    logic [RUN_LEN_W-1:0]  r_hit_cnt;

    // end-of-run snapshot and result staging
    logic [SUM_W-1:0]      r_fin_sum;
    logic [RUN_LEN_W-1:0]  r_fin_hit;
    logic [KW-1:0]         r_top_num;
    logic [KW-1:0]         r_drain_cnt;
    logic [SW-1:0]         r_ksum;
    logic                  r_res_status;
    logic [SAMPLE_W-1:0]   r_res_avg;
    logic [SAMPLE_W-1:0]   r_res_thr;
    logic [SAMPLE_W-1:0]   r_res_tavg;
    logic [FRAC_W-1:0]     r_res_frac;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [OUT_TUSER_W-1:0] r_out_tuser;

    logic                  w_in_acc;
    logic                  w_hit;
    logic                  w_fail;
    logic [RUN_LEN_W-1:0]  w_len_eff;
    logic [RUN_LEN_W-1:0]  w_cnt_next;
    logic [RUN_LEN_W-1:0]  w_hit_next;
    logic [SUM_W-1:0]      w_sum_next;
    logic                  w_run_end;
    logic [CW-1:0]         w_keep_ext;
    logic [CW-1:0]         w_keep_eff;
    logic                  w_full;
    logic [KW-1:0]         w_kept_next;
    logic                  w_drain_step;
    logic                  w_push;

    t_cell_ctl             w_ctl;
    t_cell_link            w_link  [KEEP_MAX];
    t_cell_link            w_left  [KEEP_MAX];
    logic [SAMPLE_W-1:0]   w_right [KEEP_MAX];
    logic [KEEP_MAX-1:0]   w_in_list;
    logic [KEEP_MAX-1:0]   w_in_range;

    t_div_req              w_div_req;
    logic                  w_div_done;
    logic [DIV_NUM_W-1:0]  w_div_quo;
    logic [DIV_NUM_W-1:0]  w_run_mag;
    logic [DIV_NUM_W-1:0]  w_ksum_ext;
    logic [DIV_NUM_W-1:0]  w_ksum_mag;
    logic [DIV_DEN_W-1:0]  w_top_den;
    logic [FRAC_W-1:0]     w_frac_clamp;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len  <= RUN_LEN_RST;
            r_keep_cnt <= KEEP_CNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RUN_LENGTH: r_run_len  <= i_cfg_data[RUN_LEN_W-1:0];
                CFG_KEEP_COUNT: r_keep_cnt <= i_cfg_data[KEEP_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-sample arithmetic
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_ACCUM);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_hit         = s_axis_tuser[0];
    assign w_fail        = s_axis_tuser[1];

    always_comb begin
        // a run length of zero counts as one
        w_len_eff  = (r_run_len == '0) ? RUN_LEN_W'(1) : r_run_len;
        w_cnt_next = r_sample_cnt + RUN_LEN_W'(1);
        w_hit_next = r_hit_cnt + RUN_LEN_W'(w_hit);
        w_sum_next = r_sum + {{(SUM_W - SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata};
        // the count wrapping to zero also closes the run
        w_run_end  = (w_cnt_next >= w_len_eff) || (w_cnt_next == '0);

        // clamp keep_count into one .. KEEP_MAX
        w_keep_ext = CW'(r_keep_cnt);
        if (w_keep_ext == '0) begin
            w_keep_eff = CW'(1);
        end else if (w_keep_ext > CW'(KEEP_MAX)) begin
            w_keep_eff = CW'(KEEP_MAX);
        end else begin
            w_keep_eff = w_keep_ext;
        end

        // a full list (also one above a lowered limit) keeps its length and
        // drops its smallest entry when the sample gets in
        w_full      = CW'(r_kept_num) >= w_keep_eff;
        w_kept_next = w_full ? r_kept_num : r_kept_num + KW'(1);
    end

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    assign w_drain_step = (r_state == S_DRAIN) && (r_drain_cnt != '0);

    assign w_ctl.ins    = w_in_acc && !w_fail;
    assign w_ctl.shift  = w_drain_step;
    assign w_ctl.sample = s_axis_tdata;

    for (genvar g = 0; g < KEEP_MAX; g++) begin : g_cell
        if (g == 0) begin : g_head
            // slot zero takes the sample whenever it loses its place
            assign w_left[g].val = '0;
            assign w_left[g].ge  = 1'b1;
        end else begin : g_body
            assign w_left[g] = w_link[g-1];
        end

        if (g == KEEP_MAX - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_inner
            assign w_right[g] = w_link[g+1].val;
        end

        assign w_in_list[g]  = KW'(g) < r_kept_num;
        assign w_in_range[g] = KW'(g) < w_kept_next;

        tkrs_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_in_list   (w_in_list[g]),
            .i_in_range  (w_in_range[g]),
            .i_left      (w_left[g]),
            .i_right_val (w_right[g]),
            .o_link      (w_link[g])
        );
    end

    // ------------------------------------------------------------------
    // divider operands
    // ------------------------------------------------------------------
    always_comb begin
        w_run_mag  = r_fin_sum[SUM_W-1] ? (~r_fin_sum + SUM_W'(1)) : r_fin_sum;
        w_ksum_ext = {{(DIV_NUM_W - SW){r_ksum[SW-1]}}, r_ksum};
        w_ksum_mag = r_ksum[SW-1] ? (~w_ksum_ext + DIV_NUM_W'(1)) : w_ksum_ext;
        // an empty list divides a zero sum by one
        w_top_den  = (r_top_num == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(r_top_num);
        w_frac_clamp = (w_div_quo > DIV_NUM_W'(FRAC_ONE)) ? FRAC_ONE
                                                           : w_div_quo[FRAC_W-1:0];
    end

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        w_push          = 1'b0;
        w_div_req.start = 1'b0;
        w_div_req.neg   = 1'b0;
        w_div_req.num   = w_run_mag;
        w_div_req.den   = w_len_eff;

        unique case (r_state)
            S_ACCUM: begin
                if (w_in_acc && w_fail) begin
                    n_state = S_PUSH;
                end else if (w_in_acc && w_run_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // run average next
                w_div_req.neg = r_fin_sum[SUM_W-1];
                if (r_drain_cnt == '0) begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV_RUN;
                end
            end
            S_DIV_RUN: begin
                // kept average next
                w_div_req.neg = r_ksum[SW-1];
                w_div_req.num = w_ksum_mag;
                w_div_req.den = w_top_den;
                if (w_div_done) begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV_TOP;
                end
            end
            S_DIV_TOP: begin
                // hit fraction next
                w_div_req.num = {{(DIV_NUM_W - RUN_LEN_W - 16){1'b0}}, r_fin_hit, 16'd0};
                if (w_div_done) begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV_FRAC;
                end
            end
            S_DIV_FRAC: begin
                if (w_div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_push  = 1'b1;
                    n_state = S_ACCUM;
                end
            end
            default: n_state = S_ACCUM;
        endcase
    end

    tkrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // ------------------------------------------------------------------
    // run counters
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_num   <= '0;
            r_sample_cnt <= '0;
            r_sum        <= '0;
            r_hit_cnt    <= '0;
            r_drain_cnt  <= '0;
        end else begin
            if (w_in_acc) begin
                if (w_fail || w_run_end) begin
                    // start the next run from scratch
                    r_kept_num   <= '0;
                    r_sample_cnt <= '0;
                    r_sum        <= '0;
                    r_hit_cnt    <= '0;
                end else begin
                    r_kept_num   <= w_kept_next;
                    r_sample_cnt <= w_cnt_next;
                    r_sum        <= w_sum_next;
                    r_hit_cnt    <= w_hit_next;
                end
                if (!w_fail && w_run_end) begin
                    r_drain_cnt <= w_kept_next;
                end
            end else if (w_drain_step) begin
                r_drain_cnt <= r_drain_cnt - KW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // result staging
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_fail) begin
            r_res_status <= STATUS_ABORT;
            r_res_avg    <= '0;
            r_res_thr    <= '0;
            r_res_tavg   <= '0;
            r_res_frac   <= '0;
        end else if (w_in_acc && w_run_end) begin
            r_res_status <= STATUS_DONE;
            r_res_thr    <= '0;
            r_fin_sum    <= w_sum_next;
            r_fin_hit    <= w_hit_next;
            r_top_num    <= w_kept_next;
            r_ksum       <= '0;
        end

        // slot zero streams the list out largest first; the last word
        // read is the threshold
        if (w_drain_step) begin
            r_ksum    <= r_ksum + {{KW{w_link[0].val[SAMPLE_W-1]}}, w_link[0].val};
            r_res_thr <= w_link[0].val;
        end

        if (w_div_done) begin
            case (r_state)
                S_DIV_RUN:  r_res_avg  <= w_div_quo[SAMPLE_W-1:0];
                S_DIV_TOP:  r_res_tavg <= w_div_quo[SAMPLE_W-1:0];
                S_DIV_FRAC: r_res_frac <= w_frac_clamp;
                default: ;
            endcase
        end

        if (w_push) begin
            r_out_tdata <= {{(OUT_TDATA_W - 3 * SAMPLE_W - FRAC_W){1'b0}},
                            r_res_frac, r_res_tavg, r_res_thr, r_res_avg};
            r_out_tuser <= r_res_status;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

### tb/top_k_run_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_run_statistics_tb - self-checking bench for the run statistics block
// Streams signed Q16.16 sample words with hit and fail flags into the block.
// A cycle-free predictor in the bench keeps its own running sum, hit count
// and sorted list of largest samples. It forms every expected run result and
// checks the block's results in order. Directed runs come first, then
// random phases under several register settings, then one run long enough
// to fill the largest list.
// ----------------------------------------------------------------------------
module top_k_run_statistics_tb;
    import tkrs_pkg::*;

    localparam int KEEP_LIMIT    = KEEP_MAX_DEF;
    // settling wait, long enough for the drain of a full list plus three divides
    localparam int SETTLE_CYCLES = 800;
    localparam int LONG_HOLD     = 1500;
    localparam int PHASE_WORDS   = 60;
    // longer than the fullest list, so it fills and then only swaps
    localparam int LONG_RUN      = 600;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                fail;
        logic                hit;
        logic [SAMPLE_W-1:0] sample;
    } t_sample_word;

    typedef struct packed {
        logic                status;
        logic [SAMPLE_W-1:0] run_avg;
        logic [SAMPLE_W-1:0] threshold;
        logic [SAMPLE_W-1:0] top_avg;
        logic [FRAC_W-1:0]   hit_frac;
    } t_run_stats;

    // DUT ports; every input starts at a known value
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] sample
    logic [SAMPLE_W-1:0]    s_axis_tdata  = '0;
    // [0] hit, [1] fail
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] run_average, [63:32] top_threshold, [95:64] top_average,
    // [112:96] hit_fraction, [119:113] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] status
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    top_k_run_statistics #(
        .KEEP_MAX (KEEP_LIMIT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mirror of the register file, written together with the DUT port.
    logic [RUN_LEN_W-1:0]  run_length_reg = RUN_LEN_RST;
    logic [KEEP_CNT_W-1:0] keep_count_reg = KEEP_CNT_RST;

    // Mirror of the run state. The kept list is sorted largest first.
    int                    kept_list [KEEP_LIMIT];
    int unsigned           kept_total     = 0;
    logic [RUN_LEN_W-1:0]  samples_seen   = '0;
    longint                sum_of_samples = 0;
    logic [RUN_LEN_W-1:0]  hit_total      = '0;

    t_sample_word pending_words [$];
    t_run_stats   expected_stats [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    // idling control; the calm flags and hold_asks are set by the stimulus process
    bit sender_calm    = 1'b0;
    bit receiver_calm  = 1'b0;
    int hold_asks      = 0;
    int hold_taken     = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Generous ceiling: far above the slowest legal run with every stall.
    initial begin
        #60_000_000;
        $display("top_k_run_statistics: mismatch");
        $finish;
    end

    function automatic void clear_run_stats();
        kept_total     = 0;
        samples_seen   = '0;
        sum_of_samples = 0;
        hit_total      = '0;
    endfunction

    // Fold one accepted word into the mirrored run state; queue the result
    // it causes, if any.
    function automatic void predict_run_stats(t_sample_word w);
        t_run_stats  r;
        int unsigned len;
        int unsigned limit;
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        int          v;
        longint      kept_sum;
        longint      frac;

        r   = '0;
        len = (run_length_reg == '0) ? 1 : run_length_reg;

        // abort: drop the sample, report status with zero values
        if (w.fail) begin
            r.status = STATUS_ABORT;
            expected_stats.push_back(r);
            clear_run_stats();
            return;
        end

        v = w.sample;
        sum_of_samples += v;
        if (w.hit)
            hit_total++;

        // Keep the largest samples. A full list (or one left over-full by a
        // lowered keep count) only swaps out its smallest entry, and only
        // for a strictly greater sample. Equal values go behind equals.
        limit = keep_count_reg;
        if (limit == 0)
            limit = 1;
        if (limit > KEEP_LIMIT)
            limit = KEEP_LIMIT;
        n = kept_total;
        if (n >= limit && v <= kept_list[n-1]) begin
            // not large enough to enter
        end else begin
            if (n >= limit)
                n--;
            pos = n;
            while (pos > 0 && kept_list[pos-1] < v) begin
                kept_list[pos] = kept_list[pos-1];
                pos--;
            end
            kept_list[pos] = v;
            kept_total     = n + 1;
        end

        samples_seen++;
        if (samples_seen < len && samples_seen != '0)
            return;

        // run complete: all divisions truncate toward zero
        r.status  = STATUS_DONE;
        r.run_avg = SAMPLE_W'(sum_of_samples / longint'(len));
        if (kept_total > 0) begin
            kept_sum = 0;
            for (i = 0; i < kept_total; i++)
                kept_sum += kept_list[i];
            r.threshold = kept_list[kept_total-1];
            r.top_avg   = SAMPLE_W'(kept_sum / longint'(kept_total));
        end
        frac       = (longint'(hit_total) << 16) / longint'(len);
        r.hit_frac = (frac > longint'(FRAC_ONE)) ? FRAC_ONE : FRAC_W'(frac);
        expected_stats.push_back(r);
        clear_run_stats();
    endfunction

    // Idle length: mostly none, often short, rarely long.
    function automatic int pick_gap(bit calm, int longest);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, longest);
    endfunction

    // Sample mix: the two extremes, a narrow band that makes ties, and
    // full-range values.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_word(logic [SAMPLE_W-1:0] sample, logic hit, logic fail);
        t_sample_word w;
        w.fail   = fail;
        w.hit    = hit;
        w.sample = sample;
        pending_words.push_back(w);
    endfunction

    // Mostly complete runs with random content; some runs are cut by an
    // abort, a few stray aborts fall between runs, and the phase may stop
    // partway into a run so the next register write lands mid-run.
    function automatic void add_random_phase(int words);
        int len;
        int made;
        int cut;
        int i;
        len  = (run_length_reg == '0) ? 1 : run_length_reg;
        made = 0;
        while (made < words) begin
            if ($urandom_range(0, 99) < 4) begin
                add_word($urandom(), 1'($urandom_range(0, 1)), 1'b1);
                made++;
            end
            cut = ($urandom_range(0, 99) < 12) ? $urandom_range(0, len - 1) : len;
            for (i = 0; i < cut; i++)
                add_word(pick_sample(), 1'($urandom_range(0, 1)), 1'b0);
            made += cut;
            if (cut < len) begin
                add_word($urandom(), 1'($urandom_range(0, 1)), 1'b1);
                made++;
            end
        end
        cut = $urandom_range(0, (len - 1 < 20) ? len - 1 : 20);
        for (i = 0; i < cut; i++)
            add_word(pick_sample(), 1'($urandom_range(0, 1)), 1'b0);
    endfunction

    // One register write; the mirror follows at once since the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_RUN_LENGTH)
            run_length_reg = data;
        else if (idx == CFG_KEEP_COUNT)
            keep_count_reg = data[KEEP_CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold the sender until every word is taken and every result is back,
    // then let the block finish any drain or divide still in flight.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_stats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sender: predict on every accepted word, then offer the next one
    // after a random gap.
    always @(posedge i_clk) begin : sample_driver
        t_sample_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_run_stats({s_axis_tuser[1], s_axis_tuser[0], s_axis_tdata});
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_axis_tdata  <= w.sample;
                    s_axis_tuser  <= {w.fail, w.hit};
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(sender_calm, 60);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest expectation;
    // stall at random, and on request hold off for a long stretch.
    always @(posedge i_clk) begin : result_monitor
        t_run_stats got;
        t_run_stats want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = m_axis_tuser[0];
                got.run_avg   = m_axis_tdata[31:0];
                got.threshold = m_axis_tdata[63:32];
                got.top_avg   = m_axis_tdata[95:64];
                got.hit_frac  = m_axis_tdata[112:96];
                results_seen++;
                if (expected_stats.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d unexpected: status=%0b avg=%h thr=%h top=%h frac=%h",
                                 results_seen, got.status, got.run_avg, got.threshold,
                                 got.top_avg, got.hit_frac);
                end else begin
                    want = expected_stats.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d: expected status=%0b avg=%h thr=%h top=%h ",
                                      "frac=%h, got status=%0b avg=%h thr=%h top=%h frac=%h"},
                                     results_seen, want.status, want.run_avg, want.threshold,
                                     want.top_avg, want.hit_frac, got.status, got.run_avg,
                                     got.threshold, got.top_avg, got.hit_frac);
                    end
                end
            end

            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_taken != hold_asks) begin
                hold_taken++;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(receiver_calm, 80);
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        int i;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero run length and zero keep count both act as one: every word
        // closes a run. Extremes of the sample, then an abort.
        write_reg(CFG_RUN_LENGTH, '0);
        write_reg(CFG_KEEP_COUNT, '0);
        add_word(SAMPLE_MAX, 1'b1, 1'b0);
        add_word(SAMPLE_MIN, 1'b0, 1'b0);
        add_word(32'h1234_5678, 1'b1, 1'b1);
        wait_idle();

        // Ties and strict replacement in a list of two, an abort mid-run,
        // then a run of extremes with every word a hit.
        write_reg(CFG_RUN_LENGTH, 16'd4);
        write_reg(CFG_KEEP_COUNT, 16'd2);
        add_word(32'h0005_0000, 1'b1, 1'b0);
        add_word(32'h0005_0000, 1'b0, 1'b0);
        add_word(32'h0007_0000, 1'b1, 1'b0);
        add_word(32'h0003_0000, 1'b0, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        add_word(SAMPLE_MAX, 1'b1, 1'b1);
        add_word(SAMPLE_MIN, 1'b1, 1'b0);
        add_word(SAMPLE_MIN, 1'b1, 1'b0);
        add_word(SAMPLE_MAX, 1'b1, 1'b0);
        add_word(SAMPLE_MAX, 1'b1, 1'b0);
        wait_idle();

        // Keep count above the list size saturates; stop partway into the
        // run and lower the keep count below what the list already holds.
        write_reg(CFG_KEEP_COUNT, 16'd1023);
        write_reg(CFG_RUN_LENGTH, 16'd5);
        add_word(32'h0000_0000, 1'b0, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        add_word(SAMPLE_MAX, 1'b0, 1'b0);
        add_word(32'h0000_0001, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_KEEP_COUNT, 16'd1);
        add_word(32'h0000_0002, 1'b1, 1'b0);
        wait_idle();

        // Shorten the run below the samples already taken: the next word
        // closes it and the hit fraction clamps at one. Then an abort with
        // nothing accumulated.
        write_reg(CFG_RUN_LENGTH, 16'd6);
        write_reg(CFG_KEEP_COUNT, 16'd3);
        for (i = 0; i < 4; i++)
            add_word(pick_sample(), 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_RUN_LENGTH, 16'd2);
        add_word(32'h0001_8000, 1'b1, 1'b0);
        add_word(SAMPLE_MIN, 1'b0, 1'b1);
        wait_idle();

        // Back up the output: short runs, a free-running sender and a long
        // receiver hold-off, so results pile up and the input stalls.
        write_reg(CFG_RUN_LENGTH, 16'd2);
        write_reg(CFG_KEEP_COUNT, 16'd3);
        sender_calm = 1'b1;
        hold_asks++;
        add_random_phase(PHASE_WORDS);
        wait_idle();
        sender_calm = 1'b0;

        // Random phases under changing settings; one phase runs without idling.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0:       write_reg(CFG_RUN_LENGTH, CFG_DATA_W'($urandom_range(1, 8)));
                1:       write_reg(CFG_RUN_LENGTH, CFG_DATA_W'($urandom_range(9, 30)));
                2:       write_reg(CFG_RUN_LENGTH, CFG_DATA_W'($urandom_range(60, 120)));
                default: write_reg(CFG_RUN_LENGTH, CFG_DATA_W'($urandom_range(0, 16)));
            endcase
            if (phase == 2)
                write_reg(CFG_KEEP_COUNT, CFG_DATA_W'($urandom_range(500, 1023)));
            else if (phase == 5)
                write_reg(CFG_KEEP_COUNT, CFG_DATA_W'($urandom()));
            else
                write_reg(CFG_KEEP_COUNT, CFG_DATA_W'($urandom_range(0, 12)));
            sender_calm   = (phase == 3);
            receiver_calm = (phase == 3);
            add_random_phase(PHASE_WORDS);
            wait_idle();
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;

        // One run with the fullest list, long enough that the list fills
        // and later samples only swap out its smallest entry.
        write_reg(CFG_RUN_LENGTH, CFG_DATA_W'(LONG_RUN));
        write_reg(CFG_KEEP_COUNT, CFG_DATA_W'(KEEP_LIMIT));
        sender_calm = 1'b1;
        for (i = 0; i < LONG_RUN; i++)
            add_word(pick_sample(), 1'($urandom_range(0, 1)), 1'b0);
        wait_idle();

        if (mismatch_count == 0 && expected_stats.size() == 0) begin
            $display("top_k_run_statistics: match");
        end else begin
            $display("top_k_run_statistics: mismatch");
        end
        $finish;
    end

endmodule

### top_k_run_statistics.f
rtl/tkrs_pkg.sv
rtl/tkrs_cell.sv
rtl/tkrs_div.sv
rtl/top_k_run_statistics.sv
tb/top_k_run_statistics_tb.sv
